>>> src/dau_pkg.sv
package dau_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNDERFLW = 2'd2;
    localparam logic [1:0] ST_DIVZERO  = 2'd3;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [29:0] NS_MAX     = 30'd999999999;

    // cells in the seconds and the nanoseconds division rows
    localparam int SECS_CELLS = 64;
    localparam int NANO_CELLS = 30;

    // operand and partial result data riding alongside the divider
    typedef struct packed {
        logic [1:0]  op;
        logic [29:0] an;
        logic [31:0] f;
        logic [63:0] rs;
        logic [29:0] rn;
        logic [1:0]  st;
    } t_side;

    // state of one division cell: partial remainder, dividend/quotient word
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] word;
        logic [31:0] dvs;
        t_side       side;
    } t_div;

endpackage

>>> src/dau_cell.sv
module dau_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  dau_pkg::t_div i_d,
    output logic          o_vld,
    output dau_pkg::t_div o_d
);

    logic [32:0]   w_trial;
    logic [32:0]   w_diff;
    logic          w_ge;
    dau_pkg::t_div n_d;
    dau_pkg::t_div r_d;
    logic          r_vld;

    // one restoring division step: shift in the next dividend bit
    always_comb begin
        w_trial = {i_d.rem, i_d.word[63]};
        w_diff  = w_trial - {1'b0, i_d.dvs};
        w_ge    = (w_trial >= {1'b0, i_d.dvs});
        n_d      = i_d;
        n_d.rem  = w_ge ? w_diff[31:0] : w_trial[31:0];
        n_d.word = {i_d.word[62:0], w_ge};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // cell data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

>>> src/dau_front.sv
module dau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [1:0]    i_op,
    input  logic [63:0]   i_a_secs,
    input  logic [29:0]   i_a_nanos,
    input  logic [63:0]   i_b_secs,
    input  logic [29:0]   i_b_nanos,
    input  logic [31:0]   i_factor,
    output logic          o_vld,
    output dau_pkg::t_div o_d
);

    logic [29:0] w_an;
    logic [29:0] w_bn;
    logic [30:0] w_ns;
    logic        w_cy;
    logic [30:0] w_nsr;
    logic [64:0] w_sum;
    logic        w_brw;
    logic        w_under;
    logic [63:0] w_dif;
    logic [30:0] w_dn;
    logic [63:0] n1_rs;
    logic [29:0] n1_rn;
    logic [1:0]  n1_st;

    logic        r1_vld;
    logic [1:0]  r1_op;
    logic [63:0] r1_as;
    logic [29:0] r1_an;
    logic [31:0] r1_f;
    logic [63:0] r1_plo;
    logic [63:0] r1_phi;
    logic [61:0] r1_tn;
    logic [63:0] r1_rs;
    logic [29:0] r1_rn;
    logic [1:0]  r1_st;

    logic [95:0]   w_sc;
    dau_pkg::t_div n_d;
    dau_pkg::t_div r_d;
    logic          r_vld;

    // clamp nanoseconds, add and subtract
    always_comb begin
        w_an    = (i_a_nanos > dau_pkg::NS_MAX) ? dau_pkg::NS_MAX : i_a_nanos;
        w_bn    = (i_b_nanos > dau_pkg::NS_MAX) ? dau_pkg::NS_MAX : i_b_nanos;
        w_ns    = {1'b0, w_an} + {1'b0, w_bn};
        w_cy    = (w_ns >= {1'b0, dau_pkg::NS_PER_SEC});
        w_nsr   = w_cy ? (w_ns - {1'b0, dau_pkg::NS_PER_SEC}) : w_ns;
        w_sum   = {1'b0, i_a_secs} + {1'b0, i_b_secs} + {64'd0, w_cy};
        w_brw   = (w_an < w_bn);
        w_under = (i_a_secs < i_b_secs) || ((i_a_secs == i_b_secs) && w_brw);
        w_dif   = i_a_secs - i_b_secs - {63'd0, w_brw};
        w_dn    = w_brw ? ({1'b0, w_an} + {1'b0, dau_pkg::NS_PER_SEC} - {1'b0, w_bn})
                        : ({1'b0, w_an} - {1'b0, w_bn});
        n1_rs = '0;
        n1_rn = '0;
        n1_st = dau_pkg::ST_OK;
        unique case (i_op)
            dau_pkg::OP_ADD: begin
                n1_rs = w_sum[63:0];
                n1_rn = w_nsr[29:0];
                n1_st = w_sum[64] ? dau_pkg::ST_OVERFLOW : dau_pkg::ST_OK;
            end
            dau_pkg::OP_SUB: begin
                n1_rs = w_dif;
                n1_rn = w_dn[29:0];
                n1_st = w_under ? dau_pkg::ST_UNDERFLW : dau_pkg::ST_OK;
            end
            default: begin
                n1_st = dau_pkg::ST_OK;
            end
        endcase
    end

    // first stage: products and add/subtract results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op  <= i_op;
            r1_as  <= i_a_secs;
            r1_an  <= w_an;
            r1_f   <= i_factor;
            r1_plo <= i_a_secs[31:0] * i_factor;
            r1_phi <= i_a_secs[63:32] * i_factor;
            r1_tn  <= 62'(w_an) * 62'(i_factor);
            r1_rs  <= n1_rs;
            r1_rn  <= n1_rn;
            r1_st  <= n1_st;
        end
    end

    // second stage: full seconds product, divider set-up
    always_comb begin
        w_sc = {r1_phi, 32'd0} + {32'd0, r1_plo};
        n_d.side.op = r1_op;
        n_d.side.an = r1_an;
        n_d.side.f  = r1_f;
        n_d.side.rs = r1_rs;
        n_d.side.rn = r1_rn;
        n_d.side.st = r1_st;
        n_d.rem     = '0;
        n_d.word    = {2'd0, r1_tn};
        n_d.dvs     = {2'd0, dau_pkg::NS_PER_SEC};
        unique case (r1_op)
            dau_pkg::OP_MUL: begin
                n_d.side.rs = w_sc[63:0];
                n_d.side.st = (|w_sc[95:64]) ? dau_pkg::ST_OVERFLOW : dau_pkg::ST_OK;
            end
            dau_pkg::OP_DIV: begin
                n_d.word = r1_as;
                n_d.dvs  = r1_f;
            end
            default: begin
                n_d.word = {2'd0, r1_tn};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

>>> src/duration_arithmetic_unit.sv
// Duration arithmetic unit: add, subtract, multiply or divide durations
// held as 64-bit seconds plus nanoseconds.
// Input channel s_axis: one word per operation, operation code in tuser.
// Output channel m_axis: one result word per input word, in order.
// Configuration channel cfg: one bit, saturating mode; always ready, to be
// written only while no word is in flight.
// The path from input acceptance to output valid runs through two front
// stages (products, add/subtract), a row of 64 division cells for the
// seconds quotient, one stage forming the nanosecond dividend, a row of
// 30 division cells for the nanosecond quotient and the output register.
// Throughput is one word per cycle while the receiver does not stall;
// every cell does one restoring division step per cycle.
// Reset clears all valid flags and selects checked mode.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_axis_tready drops until the result is taken.
module duration_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_secs, a_nanos, b_secs, b_nanos, factor, zero fill
    input  logic [223:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_secs, res_nanos, status
    output logic [95:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);

    localparam int SC = dau_pkg::SECS_CELLS;
    localparam int NC = dau_pkg::NANO_CELLS;

    logic          w_en;
    logic          r_sat;
    logic          sv [0:SC];
    dau_pkg::t_div sd [0:SC];
    logic          nv [0:NC];
    dau_pkg::t_div nd [0:NC];

    logic [61:0]   w_x;
    logic [64:0]   w_ms;
    dau_pkg::t_div n_mid;

    logic [63:0]   n_rs;
    logic [29:0]   n_rn;
    logic [1:0]    n_st;
    logic          r_ov;
    logic [63:0]   r_rs;
    logic [29:0]   r_rn;
    logic [1:0]    r_st;

    // pipeline advances unless a result waits and the receiver is not ready
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cfg_valid) begin
            r_sat <= i_cfg_data;
        end
    end

    dau_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (s_axis_tvalid),
        .i_op      (s_axis_tuser),
        .i_a_secs  (s_axis_tdata[63:0]),
        .i_a_nanos (s_axis_tdata[93:64]),
        .i_b_secs  (s_axis_tdata[157:94]),
        .i_b_nanos (s_axis_tdata[187:158]),
        .i_factor  (s_axis_tdata[219:188]),
        .o_vld     (sv[0]),
        .o_d       (sd[0])
    );

    // seconds division row
    for (genvar k = 0; k < SC; k++) begin : g_secs
        dau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (sv[k]),
            .i_d     (sd[k]),
            .o_vld   (sv[k+1]),
            .o_d     (sd[k+1])
        );
    end

    // finish multiply, form nanosecond dividend for divide
    always_comb begin
        w_x   = 62'(sd[SC].rem) * 62'(dau_pkg::NS_PER_SEC) + 62'(sd[SC].side.an);
        w_ms  = {1'b0, sd[SC].side.rs} + {1'b0, sd[SC].word};
        n_mid      = sd[SC];
        n_mid.rem  = w_x[61:30];
        n_mid.word = {w_x[29:0], 34'd0};
        n_mid.dvs  = sd[SC].side.f;
        unique case (sd[SC].side.op)
            dau_pkg::OP_MUL: begin
                n_mid.side.rs = w_ms[63:0];
                n_mid.side.rn = sd[SC].rem[29:0];
                n_mid.side.st = ((sd[SC].side.st == dau_pkg::ST_OVERFLOW) || w_ms[64])
                              ? dau_pkg::ST_OVERFLOW : dau_pkg::ST_OK;
            end
            dau_pkg::OP_DIV: begin
                n_mid.side.rs = sd[SC].word;
            end
            default: begin
                n_mid.side.rs = sd[SC].side.rs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            nv[0] <= 1'b0;
        end else if (w_en) begin
            nv[0] <= sv[SC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            nd[0] <= n_mid;
        end
    end

    // nanoseconds division row
    for (genvar k = 0; k < NC; k++) begin : g_nano
        dau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (nv[k]),
            .i_d     (nd[k]),
            .o_vld   (nv[k+1]),
            .o_d     (nd[k+1])
        );
    end

    // final result select, checked or saturating
    always_comb begin
        n_rs = nd[NC].side.rs;
        n_rn = nd[NC].side.rn;
        n_st = nd[NC].side.st;
        if (nd[NC].side.op == dau_pkg::OP_DIV) begin
            n_rn = nd[NC].word[29:0];
            n_st = (nd[NC].side.f == 32'd0) ? dau_pkg::ST_DIVZERO : dau_pkg::ST_OK;
        end
        if (n_st != dau_pkg::ST_OK) begin
            if (r_sat && (n_st == dau_pkg::ST_OVERFLOW)) begin
                n_rs = '1;
                n_rn = dau_pkg::NS_MAX;
            end else begin
                n_rs = '0;
                n_rn = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= nv[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rs <= n_rs;
            r_rn <= n_rn;
            r_st <= n_st;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_st, r_rn, r_rs};

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // input ready follows the output stall
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output stall");

    // errored results other than saturated overflow are zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_st != dau_pkg::ST_OK)
            && !(r_sat && (r_st == dau_pkg::ST_OVERFLOW)))
        |-> ((r_rs == 64'd0) && (r_rn == 30'd0)))
        else $error("failed result not cleared");

    // nanoseconds stay below one second
    a_nanos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_rn <= dau_pkg::NS_MAX))
        else $error("nanoseconds out of range");

endmodule
